>>> design/sort_desc_dedupe_eight_core_assert.svh
// Assertion macros shared by the design files.
// All checks are clocked on clk_i and switched off while rst_ni is low.
`ifndef SORT_DESC_DEDUPE_EIGHT_CORE_ASSERT_SVH
`define SORT_DESC_DEDUPE_EIGHT_CORE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define SDD_ASSERT_HOLDS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sdd assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define SDD_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SDD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdd assertion failed");

`endif

>>> design/sdd_pkg.sv
package sdd_pkg;

  // Upper bound on the number of values per item
  localparam int MaxValues = 16;

  // What one lane finds out about its own value
  typedef struct packed {
    logic                 keep;     // first occurrence of this value in the item
    logic [MaxValues-1:0] greater;  // bit j: value j is larger than this lane's value
  } lane_t;

endpackage

>>> design/sdd_if.sv
// Input channel: one item of NUM_VALUES values, packed value 0 in the low bits
interface sdd_value_if #(
  parameter int NUM_VALUES  = 8,
  parameter int VALUE_WIDTH = 16
) ();
  logic                              valid;
  logic                              ready;
  logic [NUM_VALUES*VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: sorted distinct values, largest in the low bits
interface sdd_sorted_if #(
  parameter int NUM_VALUES  = 8,
  parameter int VALUE_WIDTH = 16
) ();
  logic                              valid;
  logic                              ready;
  logic [NUM_VALUES*VALUE_WIDTH-1:0] sorted;

  modport source (output valid, output sorted, input ready);
  modport sink   (input valid, input sorted, output ready);
endinterface

>>> design/sdd_lane.sv
// One lane: compares its own value against every value of the item
module sdd_lane #(
  parameter int NUM_VALUES  = 8,
  parameter int VALUE_WIDTH = 16,
  parameter int LANE        = 0
) (
  input  logic [NUM_VALUES*VALUE_WIDTH-1:0] values_i,
  output sdd_pkg::lane_t                    status_o
);

  logic [VALUE_WIDTH-1:0] own;

  assign own = values_i[LANE*VALUE_WIDTH +: VALUE_WIDTH];

  // Duplicate check against earlier lanes, greater-than against all lanes
  always_comb begin
    logic [VALUE_WIDTH-1:0] other;
    status_o      = '0;
    status_o.keep = 1'b1;
    for (int j = 0; j < NUM_VALUES; j++) begin
      other = values_i[j*VALUE_WIDTH +: VALUE_WIDTH];
      if ((j < LANE) && (other == own)) begin
        status_o.keep = 1'b0;
      end
      status_o.greater[j] = (other > own);
    end
  end

endmodule

>>> design/sdd_merge.sv
// Merge: ranks each kept value by the number of larger kept values
// and places it in that slot; empty slots read zero.
module sdd_merge #(
  parameter int NUM_VALUES  = 8,
  parameter int VALUE_WIDTH = 16
) (
  input  logic [NUM_VALUES*VALUE_WIDTH-1:0] values_i,
  input  sdd_pkg::lane_t                    lanes_i [NUM_VALUES],
  output logic [NUM_VALUES*VALUE_WIDTH-1:0] sorted_o
);

  localparam int CntW = $clog2(NUM_VALUES);

  logic [NUM_VALUES-1:0] keep_vec;
  logic [CntW-1:0]       rank [NUM_VALUES];

  // Rank = count of distinct larger values
  always_comb begin
    logic [NUM_VALUES-1:0] mask;
    for (int i = 0; i < NUM_VALUES; i++) begin
      keep_vec[i] = lanes_i[i].keep;
    end
    for (int i = 0; i < NUM_VALUES; i++) begin
      mask    = lanes_i[i].greater[NUM_VALUES-1:0] & keep_vec;
      rank[i] = '0;
      for (int j = 0; j < NUM_VALUES; j++) begin
        rank[i] = rank[i] + CntW'(mask[j]);
      end
    end
  end

  // One-hot select per slot; at most one kept lane owns each rank
  always_comb begin
    logic [VALUE_WIDTH-1:0] slot;
    sorted_o = '0;
    for (int k = 0; k < NUM_VALUES; k++) begin
      slot = '0;
      for (int i = 0; i < NUM_VALUES; i++) begin
        if (keep_vec[i] && (rank[i] == CntW'(k))) begin
          slot = slot | values_i[i*VALUE_WIDTH +: VALUE_WIDTH];
        end
      end
      sorted_o[k*VALUE_WIDTH +: VALUE_WIDTH] = slot;
    end
  end

endmodule

>>> design/sort_desc_dedupe_eight_core.sv
// The lane compare stage and the merge stage are each one register deep.
// Throughput: one item per cycle while the output is ready; each stage
// advances when it is empty or when the stage after it advances.
// Ready is combinational from the output ready through both stages.
// Reset (rst_ni low, asynchronous) empties both stages; payload registers are not reset.
`include "sort_desc_dedupe_eight_core_assert.svh"

module sort_desc_dedupe_eight_core #(
  parameter int NUM_VALUES  = 8,
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sdd_value_if.sink          in_i,
  sdd_sorted_if.source       out_o
);

  logic [NUM_VALUES*VALUE_WIDTH-1:0] value_q;
  sdd_pkg::lane_t                    lane_d [NUM_VALUES];
  sdd_pkg::lane_t                    lane_q [NUM_VALUES];
  logic                              s1_valid_q;
  logic [NUM_VALUES*VALUE_WIDTH-1:0] sorted_d;
  logic [NUM_VALUES*VALUE_WIDTH-1:0] sorted_q;
  logic                              out_valid_q;
  logic                              out_adv;
  logic                              s1_adv;
  logic [NUM_VALUES-2:0]             order_ok;

  // Stall control
  assign out_adv  = !out_valid_q || out_o.ready;
  assign s1_adv   = !s1_valid_q || out_adv;
  assign in_i.ready = s1_adv;

  // Lanes, one per value
  for (genvar g = 0; g < NUM_VALUES; g++) begin : g_lane
    sdd_lane #(
      .NUM_VALUES  (NUM_VALUES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .LANE        (g)
    ) u_lane (
      .values_i (in_i.value),
      .status_o (lane_d[g])
    );
  end

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_i.valid) begin
      value_q <= in_i.value;
      lane_q  <= lane_d;
    end
  end

  sdd_merge #(
    .NUM_VALUES  (NUM_VALUES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_merge (
    .values_i (value_q),
    .lanes_i  (lane_q),
    .sorted_o (sorted_d)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      sorted_q <= sorted_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sorted = sorted_q;

  // Descending order check: each slot larger than the next, or the next is fill
  always_comb begin
    logic [VALUE_WIDTH-1:0] cur;
    logic [VALUE_WIDTH-1:0] nxt;
    for (int k = 0; k < NUM_VALUES - 1; k++) begin
      cur         = sorted_q[k*VALUE_WIDTH +: VALUE_WIDTH];
      nxt         = sorted_q[(k+1)*VALUE_WIDTH +: VALUE_WIDTH];
      order_ok[k] = (cur > nxt) || (nxt == '0);
    end
  end

  `SDD_ASSERT_NEXT(a_in_to_s1, in_i.valid && in_i.ready, s1_valid_q)
  `SDD_ASSERT_NEXT(a_s1_to_out, s1_valid_q && out_adv, out_valid_q)
  `SDD_ASSERT_IMPLIES(a_stall_full, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready)
  `SDD_ASSERT_IMPLIES(a_sorted_order, out_valid_q, &order_ok)

endmodule
